### rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/core/qti_pkg.sv
`default_nettype none
package qti_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  // wide enough for every determinant numerator at the default fraction width
  localparam int unsigned WIDE_W        = 132;
  localparam int unsigned MULB_W        = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned MUL_STEPS     = 14;
  localparam int unsigned STEP_W        = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT1_X = 3'd0,
    REG_POINT2_X = 3'd1,
    REG_POINT3_X = 3'd2,
    REG_POINT1_Y = 3'd3,
    REG_POINT2_Y = 3'd4,
    REG_POINT3_Y = 3'd5
  } cfg_reg_e;

  localparam logic [2:0][DATA_W-1:0] PX_RESET = {32'd196608, 32'd131072, 32'd65536};
  localparam logic [2:0][DATA_W-1:0] PY_RESET = {32'd589824, 32'd262144, 32'd65536};

  // coefficient solver sequencer
  typedef enum logic [6:0] {
    SOL_IDLE   = 7'b0000001,
    SOL_MLOAD  = 7'b0000010,
    SOL_MUL    = 7'b0000100,
    SOL_MSTORE = 7'b0001000,
    SOL_DLOAD  = 7'b0010000,
    SOL_DIV    = 7'b0100000,
    SOL_DSTORE = 7'b1000000
  } sol_state_e;

  // destinations of the solver products
  typedef enum logic [3:0] {
    DST_T  = 4'd0,
    DST_D  = 4'd1,
    DST_P1 = 4'd2,
    DST_P2 = 4'd3,
    DST_P3 = 4'd4,
    DST_Q1 = 4'd5,
    DST_Q2 = 4'd6,
    DST_Q3 = 4'd7,
    DST_NB = 4'd8,
    DST_NC = 4'd9
  } sol_dst_e;

  // parabola coefficients and solve status
  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic                     sat;
    logic                     singular;
  } coef_t;

endpackage
`default_nettype wire

### rtl/core/quadratic_three_point_interpolator_top.sv
`default_nettype none
// channel   direction  handshake                      payload
// sample    in         start_i high, busy_o low       sample_x_i
// result    out        result_valid_o, one cycle      value_y_o, singular_o, saturated_o
// config    in         cfg_valid_i and cfg_ready_o    cfg_index_i, cfg_data_i
//
// one sample per cycle while busy_o is low; its result is flagged by result_valid_o
// the coefficients are solved by a serial shift-add multiplier and a restoring
// divider after reset and after each configuration write (the divisions are
// skipped when the points are singular), busy_o is high meanwhile
// the receiver cannot stall, so the pipeline advances every cycle
module quadratic_three_point_interpolator_top import qti_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic signed [DATA_W-1:0] sample_x_i,
  output logic                          result_valid_o,
  output logic signed [DATA_W-1:0]      value_y_o,
  output logic                          singular_o,
  output logic                          saturated_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned NUM_W = 100;
  localparam int unsigned T_W   = 65;

  logic [2:0][DATA_W-1:0] px_q, py_q;
  logic                   cfg_we, accept, sol_busy;
  coef_t                  coef;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign busy_o      = sol_busy | cfg_valid_i;
  assign accept      = start_i & ~busy_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= PX_RESET;
      py_q <= PY_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_POINT1_X: px_q[0] <= cfg_data_i;
        REG_POINT2_X: px_q[1] <= cfg_data_i;
        REG_POINT3_X: px_q[2] <= cfg_data_i;
        REG_POINT1_Y: py_q[0] <= cfg_data_i;
        REG_POINT2_Y: py_q[1] <= cfg_data_i;
        REG_POINT3_Y: py_q[2] <= cfg_data_i;
        default:      px_q    <= px_q;
      endcase
    end
  end

  qti_solver #(
    .FRAC_BITS (FRAC_BITS)
  ) u_solver (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we),
    .pt_x_i    (px_q),
    .pt_y_i    (py_q),
    .busy_o    (sol_busy),
    .coef_o    (coef)
  );

  // valid bits
  logic [5:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept};
    end
  end

  // evaluation pipeline, horner form ((a*x + b*s)*x + c*s*s) / (s*s)
  logic signed [DATA_W-1:0]     x1_q, x2_q, x3_q;
  logic signed [2*DATA_W-1:0]   m1_q;
  logic signed [T_W-1:0]        t1_q, plo_q, plo4_q, phi_q;
  logic signed [DATA_W:0]       thi_q;
  logic signed [NUM_W-1:0]      num_q;
  logic [NUM_W-1:0]             mag_q;
  logic                         neg6_q;

  localparam logic [NUM_W-1:0] HALF = NUM_W'(1) << (2 * FRAC_BITS - 1);

  logic [NUM_W-1:0] qv;
  logic             over;
  assign qv   = mag_q >> (2 * FRAC_BITS);
  assign over = neg6_q ? (qv > NUM_W'(64'h8000_0000)) : (qv > NUM_W'(64'h7fff_ffff));

  always_ff @(posedge clk_i) begin
    // stage 1: a * x
    m1_q   <= $signed(coef.a) * sample_x_i;
    x1_q   <= sample_x_i;
    // stage 2: add b scaled
    t1_q   <= T_W'(m1_q) + (T_W'($signed(coef.b)) <<< FRAC_BITS);
    x2_q   <= x1_q;
    // stage 3: low partial product
    plo_q  <= $signed({1'b0, t1_q[DATA_W-1:0]}) * x2_q;
    thi_q  <= $signed(t1_q[T_W-1:DATA_W]);
    x3_q   <= x2_q;
    // stage 4: high partial product
    phi_q  <= thi_q * x3_q;
    plo4_q <= plo_q;
    // stage 5: full numerator
    num_q  <= (NUM_W'(phi_q) <<< DATA_W) + NUM_W'(plo4_q)
              + (NUM_W'($signed(coef.c)) <<< (2 * FRAC_BITS));
    // stage 6: magnitude plus rounding half
    mag_q  <= (num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q)) + HALF;
    neg6_q <= num_q[NUM_W-1];
  end

  // stage 7: scale down, clip, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef.singular) begin
      value_y_o   <= '0;
      singular_o  <= 1'b1;
      saturated_o <= 1'b0;
    end else begin
      singular_o  <= 1'b0;
      saturated_o <= coef.sat | over;
      if (over) begin
        value_y_o <= neg6_q ? $signed(32'h8000_0000) : $signed(32'h7fff_ffff);
      end else begin
        value_y_o <= neg6_q ? -$signed(qv[DATA_W-1:0]) : $signed(qv[DATA_W-1:0]);
      end
    end
  end

  // checks
  `ASSERT_PROP(a_latency, clk_i, rst_ni, accept |-> ##7 result_valid_o)
  `ASSERT_PROP(a_singular_zero, clk_i, rst_ni, (result_valid_o && singular_o) |-> (value_y_o == 0 && !saturated_o))
  `ASSERT_NEXT(a_cfg_resolve, clk_i, rst_ni, cfg_we, sol_busy)

endmodule
`default_nettype wire

### rtl/core/qti_solver.sv
`default_nettype none
module qti_solver import qti_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     restart_i,
  input  wire logic [2:0][DATA_W-1:0]   pt_x_i,
  input  wire logic [2:0][DATA_W-1:0]   pt_y_i,
  output logic                          busy_o,
  output coef_t                         coef_o
);

  localparam int unsigned CNT_W = 8;

  sol_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic [1:0]        div_k_q;
  logic [CNT_W-1:0]  cnt_q;

  logic signed [WIDE_W-1:0] t_q, det_q, nb_q, nc_q;
  logic signed [WIDE_W-1:0] p_q [3];
  logic signed [MULB_W-1:0] qx_q [3];

  logic [WIDE_W-1:0]  am_q, acc_q;
  logic [MULB_W-1:0]  bm_q;
  logic               neg_q;
  logic [WIDE_W-1:0]  num_q, den_q, quo_q;
  logic [WIDE_W-1:0]  rem_q;
  coef_t              coef_q;

  // point differences and sums
  logic signed [DATA_W:0] d12, d13, d23, s12, s13, s23;
  assign d12 = $signed({pt_x_i[0][DATA_W-1], pt_x_i[0]}) - $signed({pt_x_i[1][DATA_W-1], pt_x_i[1]});
  assign d13 = $signed({pt_x_i[0][DATA_W-1], pt_x_i[0]}) - $signed({pt_x_i[2][DATA_W-1], pt_x_i[2]});
  assign d23 = $signed({pt_x_i[1][DATA_W-1], pt_x_i[1]}) - $signed({pt_x_i[2][DATA_W-1], pt_x_i[2]});
  assign s12 = $signed({pt_x_i[0][DATA_W-1], pt_x_i[0]}) + $signed({pt_x_i[1][DATA_W-1], pt_x_i[1]});
  assign s13 = $signed({pt_x_i[0][DATA_W-1], pt_x_i[0]}) + $signed({pt_x_i[2][DATA_W-1], pt_x_i[2]});
  assign s23 = $signed({pt_x_i[1][DATA_W-1], pt_x_i[1]}) + $signed({pt_x_i[2][DATA_W-1], pt_x_i[2]});

  // operand selection per multiply step
  logic signed [WIDE_W-1:0] op_a;
  logic signed [MULB_W-1:0] op_b;
  sol_dst_e                 op_dst;
  logic                     op_sub, op_init;

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_dst  = DST_T;
    op_sub  = 1'b0;
    op_init = 1'b1;
    case (step_q)
      4'd0: begin
        op_a = WIDE_W'(d12); op_b = MULB_W'(d13); op_dst = DST_T;
      end
      4'd1: begin
        op_a = t_q; op_b = MULB_W'(d23); op_dst = DST_D;
      end
      4'd2: begin
        op_a = WIDE_W'($signed(pt_y_i[0])); op_b = MULB_W'(d23); op_dst = DST_P1;
      end
      4'd3: begin
        op_a = WIDE_W'($signed(pt_y_i[1])); op_b = MULB_W'(d13); op_dst = DST_P2;
      end
      4'd4: begin
        op_a = WIDE_W'($signed(pt_y_i[2])); op_b = MULB_W'(d12); op_dst = DST_P3;
      end
      4'd5: begin
        op_a = WIDE_W'($signed(pt_x_i[1])); op_b = MULB_W'($signed(pt_x_i[2]));
        op_dst = DST_Q1;
      end
      4'd6: begin
        op_a = WIDE_W'($signed(pt_x_i[0])); op_b = MULB_W'($signed(pt_x_i[2]));
        op_dst = DST_Q2;
      end
      4'd7: begin
        op_a = WIDE_W'($signed(pt_x_i[0])); op_b = MULB_W'($signed(pt_x_i[1]));
        op_dst = DST_Q3;
      end
      4'd8: begin
        op_a = p_q[0]; op_b = MULB_W'(s23); op_dst = DST_NB; op_sub = 1'b1;
      end
      4'd9: begin
        op_a = p_q[1]; op_b = MULB_W'(s13); op_dst = DST_NB; op_init = 1'b0;
      end
      4'd10: begin
        op_a = p_q[2]; op_b = MULB_W'(s12); op_dst = DST_NB; op_init = 1'b0; op_sub = 1'b1;
      end
      4'd11: begin
        op_a = p_q[0]; op_b = qx_q[0]; op_dst = DST_NC;
      end
      4'd12: begin
        op_a = p_q[1]; op_b = qx_q[1]; op_dst = DST_NC; op_init = 1'b0; op_sub = 1'b1;
      end
      4'd13: begin
        op_a = p_q[2]; op_b = qx_q[2]; op_dst = DST_NC; op_init = 1'b0;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // product folded into its destination
  logic signed [WIDE_W-1:0] st_base, st_val;
  always_comb begin
    case (op_dst)
      DST_NB:  st_base = op_init ? '0 : nb_q;
      DST_NC:  st_base = op_init ? '0 : nc_q;
      default: st_base = '0;
    endcase
    st_val = (neg_q ^ op_sub) ? st_base - $signed(acc_q) : st_base + $signed(acc_q);
  end

  // dividend for the current coefficient
  logic signed [WIDE_W-1:0] na, div_n;
  logic [WIDE_W-1:0]        n_mag, d_mag;
  assign na = p_q[0] - p_q[1] + p_q[2];
  always_comb begin
    case (div_k_q)
      2'd0:    div_n = na <<< (2 * FRAC_BITS);
      2'd1:    div_n = nb_q <<< FRAC_BITS;
      default: div_n = nc_q;
    endcase
  end
  assign n_mag = div_n[WIDE_W-1] ? WIDE_W'(-div_n) : WIDE_W'(div_n);
  assign d_mag = det_q[WIDE_W-1] ? WIDE_W'(-det_q) : WIDE_W'(det_q);

  // restoring division step
  logic [WIDE_W:0] rem2;
  logic            ge;
  assign rem2 = {rem_q, num_q[WIDE_W-1]};
  assign ge   = rem2 >= {1'b0, den_q};

  // quotient clipping
  localparam logic [WIDE_W-1:0] POS_LIM = WIDE_W'(64'h7fff_ffff);
  localparam logic [WIDE_W-1:0] NEG_LIM = WIDE_W'(64'h8000_0000);
  logic                     over;
  logic signed [DATA_W-1:0] cval;
  always_comb begin
    over = neg_q ? (quo_q > NEG_LIM) : (quo_q > POS_LIM);
    if (over) begin
      cval = neg_q ? $signed(32'h8000_0000) : $signed(32'h7fff_ffff);
    end else begin
      cval = neg_q ? -$signed(quo_q[DATA_W-1:0]) : $signed(quo_q[DATA_W-1:0]);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      SOL_IDLE:   state_d = SOL_IDLE;
      SOL_MLOAD:  state_d = SOL_MUL;
      SOL_MUL:    if (cnt_q == CNT_W'(MULB_W - 1)) state_d = SOL_MSTORE;
      SOL_MSTORE: state_d = (step_q == STEP_W'(MUL_STEPS - 1)) ? SOL_DLOAD : SOL_MLOAD;
      SOL_DLOAD:  state_d = (det_q == '0) ? SOL_IDLE : SOL_DIV;
      SOL_DIV:    if (cnt_q == CNT_W'(WIDE_W - 1)) state_d = SOL_DSTORE;
      SOL_DSTORE: state_d = (div_k_q == 2'd2) ? SOL_IDLE : SOL_DLOAD;
      default:    state_d = SOL_IDLE;
    endcase
    if (restart_i) state_d = SOL_MLOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SOL_MLOAD;
      step_q  <= '0;
      div_k_q <= '0;
      cnt_q   <= '0;
      coef_q  <= '0;
    end else begin
      state_q <= state_d;
      if (restart_i) begin
        step_q          <= '0;
        div_k_q         <= '0;
        coef_q.sat      <= 1'b0;
        coef_q.singular <= 1'b0;
      end else begin
        case (state_q)
          SOL_MLOAD: cnt_q <= '0;
          SOL_MUL:   cnt_q <= cnt_q + 1'b1;
          SOL_MSTORE: begin
            if (step_q != STEP_W'(MUL_STEPS - 1)) step_q <= step_q + 1'b1;
          end
          SOL_DLOAD: begin
            cnt_q <= '0;
            if (det_q == '0) begin
              coef_q.singular <= 1'b1;
              coef_q.sat      <= 1'b0;
            end
          end
          SOL_DIV:   cnt_q <= cnt_q + 1'b1;
          SOL_DSTORE: begin
            coef_q.sat <= coef_q.sat | over;
            case (div_k_q)
              2'd0:    coef_q.a <= cval;
              2'd1:    coef_q.b <= cval;
              default: coef_q.c <= cval;
            endcase
            div_k_q <= div_k_q + 1'b1;
          end
          default: cnt_q <= cnt_q;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      SOL_MLOAD: begin
        am_q  <= op_a[WIDE_W-1] ? WIDE_W'(-op_a) : WIDE_W'(op_a);
        bm_q  <= op_b[MULB_W-1] ? MULB_W'(-op_b) : MULB_W'(op_b);
        neg_q <= op_a[WIDE_W-1] ^ op_b[MULB_W-1];
        acc_q <= '0;
      end
      SOL_MUL: begin
        acc_q <= acc_q + (bm_q[0] ? am_q : '0);
        am_q  <= am_q << 1;
        bm_q  <= bm_q >> 1;
      end
      SOL_MSTORE: begin
        case (op_dst)
          DST_T:   t_q     <= st_val;
          DST_D:   det_q   <= st_val;
          DST_P1:  p_q[0]  <= st_val;
          DST_P2:  p_q[1]  <= st_val;
          DST_P3:  p_q[2]  <= st_val;
          DST_Q1:  qx_q[0] <= st_val[MULB_W-1:0];
          DST_Q2:  qx_q[1] <= st_val[MULB_W-1:0];
          DST_Q3:  qx_q[2] <= st_val[MULB_W-1:0];
          DST_NB:  nb_q    <= st_val;
          DST_NC:  nc_q    <= st_val;
          default: t_q     <= t_q;
        endcase
      end
      SOL_DLOAD: begin
        num_q <= (n_mag << 1) + d_mag;
        den_q <= d_mag << 1;
        rem_q <= '0;
        quo_q <= '0;
        neg_q <= div_n[WIDE_W-1] ^ det_q[WIDE_W-1];
      end
      SOL_DIV: begin
        rem_q <= ge ? WIDE_W'(rem2 - {1'b0, den_q}) : rem2[WIDE_W-1:0];
        quo_q <= {quo_q[WIDE_W-2:0], ge};
        num_q <= num_q << 1;
      end
      default: acc_q <= acc_q;
    endcase
  end

  assign busy_o = (state_q != SOL_IDLE);
  assign coef_o = coef_q;

endmodule
`default_nettype wire
